// ===== hdl/fdr_pkg.sv =====
// Shared constants and types for the Fresnel dielectric reflectance unit.
package fdr_pkg;

  localparam int ETA_W    = 16;
  localparam int COS_W    = 16;
  localparam int REFL_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_W     = 32;
  localparam int RAD_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 33;
  localparam int Q_W      = 17;
  localparam int PX_W     = 48;
  localparam int SX_W     = 32;
  localparam int NUMP_W   = PX_W + Q_W;
  localparam int NUMS_W   = SX_W + Q_W;
  localparam int FRAC_SH  = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_ETA_INCIDENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_TRANSMITTED = 2'd1;

  localparam logic [ETA_W-1:0]  ETA_I_RESET = 16'd4096;
  localparam logic [ETA_W-1:0]  ETA_T_RESET = 16'd6144;
  localparam logic [REFL_W-1:0] ONE_Q16     = 17'h10000;

  typedef struct packed {
    logic [COS_W-1:0] c;
    logic [ETA_W-1:0] ei;
    logic [SQ_W-1:0]  et2;
    logic             tir;
  } fdr_side_t;

  typedef struct packed {
    logic tir;
    logic sat;
  } fdr_flags_t;

endpackage

// ===== hdl/fdr_sqrt_pipe.sv =====
// Pipelined floor square root, one result bit per stage, with sideband.
module fdr_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fdr_pkg::RAD_W-1:0]  in_rad,
  input  fdr_pkg::fdr_side_t         in_side,
  output logic                       out_valid,
  output logic [fdr_pkg::ROOT_W-1:0] out_root,
  output fdr_pkg::fdr_side_t         out_side
);
  import fdr_pkg::*;

  logic              st_val  [0:ROOT_W];
  logic [RAD_W-1:0]  st_rad  [0:ROOT_W];
  logic [REM_W-1:0]  st_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] st_root [0:ROOT_W];
  fdr_side_t         st_side [0:ROOT_W];

  assign st_val[0]  = in_valid;
  assign st_rad[0]  = in_rad;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_side[0] = in_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fit;

    assign rem_sh = {st_rem[k], st_rad[k][2*(ROOT_W-1-k)+1 -: 2]};
    assign trial  = (REM_W+2)'({st_root[k], 2'b01});
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_val[k+1] <= 1'b0;
      end else begin
        st_val[k+1] <= st_val[k];
      end
      st_rad[k+1]  <= st_rad[k];
      st_side[k+1] <= st_side[k];
      st_rem[k+1]  <= fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      st_root[k+1] <= {st_root[k][ROOT_W-2:0], fit};
    end
  end

  assign out_valid = st_val[ROOT_W];
  assign out_root  = st_root[ROOT_W];
  assign out_side  = st_side[ROOT_W];

endmodule

// ===== hdl/fdr_ratio_pipe.sv =====
// Pipelined |x-y|/(x+y) in Q1.16, rounded half up, for both polarisations.
module fdr_ratio_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [fdr_pkg::PX_W-1:0] in_px,
  input  logic [fdr_pkg::PX_W-1:0] in_py,
  input  logic [fdr_pkg::SX_W-1:0] in_sx,
  input  logic [fdr_pkg::SX_W-1:0] in_sy,
  input  fdr_pkg::fdr_flags_t      in_flags,
  output logic                     out_valid,
  output logic [fdr_pkg::Q_W-1:0]  out_rp,
  output logic [fdr_pkg::Q_W-1:0]  out_rs,
  output fdr_pkg::fdr_flags_t      out_flags
);
  import fdr_pkg::*;

  logic [PX_W-1:0] dif_p, sum_p, div_p;
  logic [SX_W-1:0] dif_s, sum_s, div_s;
  logic            zero;

  assign dif_p = (in_px >= in_py) ? in_px - in_py : in_py - in_px;
  assign sum_p = in_px + in_py;
  assign dif_s = (in_sx >= in_sy) ? in_sx - in_sy : in_sy - in_sx;
  assign sum_s = in_sx + in_sy;
  assign zero  = (sum_p == '0) || (sum_s == '0);
  assign div_p = (sum_p == '0) ? PX_W'(1) : sum_p;
  assign div_s = (sum_s == '0) ? SX_W'(1) : sum_s;

  logic              st_val   [0:Q_W];
  logic [NUMP_W-1:0] st_remp  [0:Q_W];
  logic [NUMS_W-1:0] st_rems  [0:Q_W];
  logic [PX_W-1:0]   st_dp    [0:Q_W];
  logic [SX_W-1:0]   st_ds    [0:Q_W];
  logic [Q_W-1:0]    st_qp    [0:Q_W];
  logic [Q_W-1:0]    st_qs    [0:Q_W];
  fdr_flags_t        st_flags [0:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_val[0] <= 1'b0;
    end else begin
      st_val[0] <= in_valid;
    end
    st_remp[0]      <= (NUMP_W'(dif_p) << (Q_W-1)) + NUMP_W'(div_p >> 1);
    st_rems[0]      <= (NUMS_W'(dif_s) << (Q_W-1)) + NUMS_W'(div_s >> 1);
    st_dp[0]        <= div_p;
    st_ds[0]        <= div_s;
    st_qp[0]        <= '0;
    st_qs[0]        <= '0;
    st_flags[0].tir <= in_flags.tir;
    st_flags[0].sat <= in_flags.sat | zero;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [NUMP_W-1:0] shp;
    logic [NUMS_W-1:0] shs;
    logic              fitp, fits;

    assign shp  = NUMP_W'(st_dp[k]) << (Q_W-1-k);
    assign shs  = NUMS_W'(st_ds[k]) << (Q_W-1-k);
    assign fitp = st_remp[k] >= shp;
    assign fits = st_rems[k] >= shs;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_val[k+1] <= 1'b0;
      end else begin
        st_val[k+1] <= st_val[k];
      end
      st_remp[k+1]  <= fitp ? st_remp[k] - shp : st_remp[k];
      st_rems[k+1]  <= fits ? st_rems[k] - shs : st_rems[k];
      st_dp[k+1]    <= st_dp[k];
      st_ds[k+1]    <= st_ds[k];
      st_qp[k+1]    <= {st_qp[k][Q_W-2:0], fitp};
      st_qs[k+1]    <= {st_qs[k][Q_W-2:0], fits};
      st_flags[k+1] <= st_flags[k];
    end
  end

  assign out_valid = st_val[Q_W];
  assign out_rp    = st_qp[Q_W];
  assign out_rs    = st_qs[Q_W];
  assign out_flags = st_flags[Q_W];

endmodule

// ===== hdl/fresnel_dielectric_reflectance_unit.sv =====
// Fresnel dielectric reflectance unit: top level with input, product and output stages.
// Accepts one cosine every cycle (busy is never raised) and returns each result in
// order, after the input and product stages, the 31-stage square root, the 18-stage
// divider and the output stage. Results appear on out_valid for one cycle and
// cannot be held off. Index registers are written through cfg_* at any time
// (cfg_ready is always high) and are sampled as an item enters.
module fresnel_dielectric_reflectance_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [fdr_pkg::COS_W-1:0] in_cos_incident,
  output logic                          out_valid,
  output logic [fdr_pkg::REFL_W-1:0]    out_reflectance,
  output logic                          out_total_internal,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdr_pkg::ETA_W-1:0]     cfg_data
);
  import fdr_pkg::*;

  logic [ETA_W-1:0] eta_i_r, eta_t_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_i_r <= ETA_I_RESET;
      eta_t_r <= ETA_T_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ETA_INCIDENT:    eta_i_r <= cfg_data;
        CFG_ETA_TRANSMITTED: eta_t_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: magnitude and index swap
  logic [COS_W-1:0] raw, c_abs;
  logic             neg, entering;
  logic             s1_val_r;
  logic [COS_W-1:0] s1_c_r;
  logic [ETA_W-1:0] s1_ei_r, s1_et_r;

  assign raw      = in_cos_incident;
  assign neg      = raw[COS_W-1];
  assign c_abs    = neg ? COS_W'((COS_W+1)'(1 << COS_W) - (COS_W+1)'(raw)) : raw;
  assign entering = !neg && (raw != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_val_r <= 1'b0;
    end else begin
      s1_val_r <= start && !busy;
    end
    s1_c_r  <= c_abs;
    s1_ei_r <= entering ? eta_i_r : eta_t_r;
    s1_et_r <= entering ? eta_t_r : eta_i_r;
  end

  // stage 2: squares
  logic             s2_val_r;
  logic [SQ_W-1:0]  s2_csq_r, s2_ei2_r, s2_et2_r;
  logic [COS_W-1:0] s2_c_r;
  logic [ETA_W-1:0] s2_ei_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_val_r <= 1'b0;
    end else begin
      s2_val_r <= s1_val_r;
    end
    s2_csq_r <= SQ_W'(s1_c_r * s1_c_r);
    s2_ei2_r <= SQ_W'(s1_ei_r * s1_ei_r);
    s2_et2_r <= SQ_W'(s1_et_r * s1_et_r);
    s2_c_r   <= s1_c_r;
    s2_ei_r  <= s1_ei_r;
  end

  // stage 3: ei^2 * sin^2
  logic [FRAC_SH:0] sin2;
  logic             s3_val_r;
  logic [RAD_W-1:0] s3_lhs_r;
  logic [SQ_W-1:0]  s3_et2_r;
  logic [COS_W-1:0] s3_c_r;
  logic [ETA_W-1:0] s3_ei_r;

  assign sin2 = (FRAC_SH+1)'(1 << FRAC_SH) - (FRAC_SH+1)'(s2_csq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_val_r <= 1'b0;
    end else begin
      s3_val_r <= s2_val_r;
    end
    s3_lhs_r <= RAD_W'(s2_ei2_r * sin2);
    s3_et2_r <= s2_et2_r;
    s3_c_r   <= s2_c_r;
    s3_ei_r  <= s2_ei_r;
  end

  // stage 4: total internal reflection test and radicand
  logic [RAD_W-1:0] rhs;
  logic             tir;
  logic             s4_val_r;
  logic [RAD_W-1:0] s4_rad_r;
  fdr_side_t        s4_side_r;

  assign rhs = {s3_et2_r, FRAC_SH'(0)};
  assign tir = s3_lhs_r > rhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_val_r <= 1'b0;
    end else begin
      s4_val_r <= s3_val_r;
    end
    s4_rad_r      <= tir ? '0 : rhs - s3_lhs_r;
    s4_side_r.c   <= s3_c_r;
    s4_side_r.ei  <= s3_ei_r;
    s4_side_r.et2 <= s3_et2_r;
    s4_side_r.tir <= tir;
  end

  logic              rt_val;
  logic [ROOT_W-1:0] rt_root;
  fdr_side_t         rt_side;

  fdr_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_val_r),
    .in_rad    (s4_rad_r),
    .in_side   (s4_side_r),
    .out_valid (rt_val),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // stage 5: ratio operands
  logic            s5_val_r;
  logic [PX_W-1:0] s5_px_r, s5_py_r;
  logic [SX_W-1:0] s5_sx_r, s5_sy_r;
  fdr_flags_t      s5_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_val_r <= 1'b0;
    end else begin
      s5_val_r <= rt_val;
    end
    s5_px_r        <= PX_W'(rt_side.et2 * rt_side.c);
    s5_py_r        <= PX_W'(rt_side.ei * rt_root);
    s5_sx_r        <= SX_W'(rt_side.ei * rt_side.c);
    s5_sy_r        <= SX_W'(rt_root);
    s5_flags_r.tir <= rt_side.tir;
    s5_flags_r.sat <= 1'b0;
  end

  logic           dv_val;
  logic [Q_W-1:0] dv_rp, dv_rs;
  fdr_flags_t     dv_flags;

  fdr_ratio_pipe u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_val_r),
    .in_px     (s5_px_r),
    .in_py     (s5_py_r),
    .in_sx     (s5_sx_r),
    .in_sy     (s5_sy_r),
    .in_flags  (s5_flags_r),
    .out_valid (dv_val),
    .out_rp    (dv_rp),
    .out_rs    (dv_rs),
    .out_flags (dv_flags)
  );

  // stage 6: squared ratios
  logic               s6_val_r;
  logic [2*Q_W-1:0]   s6_rp2_r, s6_rs2_r;
  fdr_flags_t         s6_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_val_r <= 1'b0;
    end else begin
      s6_val_r <= dv_val;
    end
    s6_rp2_r   <= dv_rp * dv_rp;
    s6_rs2_r   <= dv_rs * dv_rs;
    s6_flags_r <= dv_flags;
  end

  // stage 7: mean, rounding and saturation
  logic [2*Q_W:0]    mean_sum;
  logic [REFL_W:0]   mean;
  logic [REFL_W-1:0] refl_nxt;
  logic              out_valid_r, out_tir_r;
  logic [REFL_W-1:0] out_refl_r;

  assign mean_sum = (2*Q_W+1)'(s6_rp2_r) + (2*Q_W+1)'(s6_rs2_r) + (2*Q_W+1)'(1 << 16);
  assign mean     = (REFL_W+1)'(mean_sum >> 17);
  assign refl_nxt = (s6_flags_r.tir || s6_flags_r.sat || mean > (REFL_W+1)'(ONE_Q16))
                    ? ONE_Q16 : REFL_W'(mean);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_tir_r   <= 1'b0;
    end else begin
      out_valid_r <= s6_val_r;
      out_tir_r   <= s6_val_r && s6_flags_r.tir;
    end
    out_refl_r <= refl_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = out_refl_r;
  assign out_total_internal = out_tir_r;

  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_total_internal |-> (out_valid && out_reflectance == ONE_Q16))
    else $error("total internal reflection without full reflectance");

  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= ONE_Q16)
    else $error("reflectance above one");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !out_total_internal))
    else $error("result strobe straight after reset");

endmodule

// ===== sim/tb_fresnel_dielectric_reflectance_unit.sv =====
// Testbench for the Fresnel dielectric reflectance unit: scoreboard class, driver tasks and top.
module tb_fresnel_dielectric_reflectance_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fdr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int PIPE_LAT = 56;
  localparam int CYCLE_LIMIT = 400000;

  class reflectance_board;
    bit [ETA_W-1:0] eta_i, eta_t;
    bit [REFL_W-1:0] want_refl[$];
    bit want_tir[$];
    int errors, taken, checked, tir_seen;

    function new();
      eta_i = ETA_I_RESET;
      eta_t = ETA_T_RESET;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [ETA_W-1:0] val);
      if (idx == CFG_ETA_INCIDENT) eta_i = val;
      else if (idx == CFG_ETA_TRANSMITTED) eta_t = val;
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit [63:0] amp_q16(bit [63:0] x, bit [63:0] y);
      bit [63:0] d, s;
      d = (x >= y) ? x - y : y - x;
      s = x + y;
      return ((d << 16) + (s >> 1)) / s;
    endfunction

    function void note(bit [COS_W-1:0] raw);
      bit neg, entering;
      bit [63:0] c, ei, et, sin2, lhs, rhs, root, px, py, sx, rp, rs, refl;
      neg = raw[COS_W-1];
      c = neg ? 64'd65536 - raw : raw;
      entering = !neg && raw != 0;
      ei = entering ? eta_i : eta_t;
      et = entering ? eta_t : eta_i;
      sin2 = (64'd1 << 30) - c * c;
      lhs = ei * ei * sin2;
      rhs = (et * et) << 30;
      taken++;
      if (lhs > rhs) begin
        want_refl.push_back(ONE_Q16);
        want_tir.push_back(1'b1);
        return;
      end
      root = isqrt(rhs - lhs);
      px = et * et * c;
      py = ei * root;
      sx = ei * c;
      if (px + py == 0 || sx + root == 0) begin
        refl = ONE_Q16;
      end else begin
        rp = amp_q16(px, py);
        rs = amp_q16(sx, root);
        refl = (rp * rp + rs * rs + (64'd1 << 16)) >> 17;
        if (refl > ONE_Q16) refl = ONE_Q16;
      end
      want_refl.push_back(refl[REFL_W-1:0]);
      want_tir.push_back(1'b0);
    endfunction

    function void check(bit [REFL_W-1:0] refl, bit tir);
      bit [REFL_W-1:0] er;
      bit et;
      if (want_refl.size() == 0) begin
        $error("unexpected result transaction: reflectance %0d total_internal %0d", refl, tir);
        errors++;
        return;
      end
      er = want_refl.pop_front();
      et = want_tir.pop_front();
      checked++;
      if (tir) tir_seen++;
      if (refl !== er) begin
        $error("reflectance: expected %0d, got %0d", er, refl);
        errors++;
      end
      if (tir !== et) begin
        $error("total_internal: expected %0d, got %0d", et, tir);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, out_total_internal, cfg_valid = 0, cfg_ready;
  logic signed [COS_W-1:0] in_cos_incident = '0;
  logic [REFL_W-1:0] out_reflectance;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ETA_W-1:0] cfg_data = '0;
  int cycles = 0, cfg_writes = 0;
  reflectance_board board = new();

  fresnel_dielectric_reflectance_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fresnel_dielectric_reflectance_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (start && !busy) board.note(in_cos_incident);
      if (out_valid) board.check(out_reflectance, out_total_internal);
    end
  end

  task automatic send(logic [COS_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_cos_incident <= v;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_cos_incident <= COS_W'($urandom);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(negedge clk);
      else repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [ETA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (board.want_refl.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  function automatic logic [COS_W-1:0] pick_cos();
    int m;
    case ($urandom_range(0, 3))
      0: m = $urandom_range(0, 600);
      1: m = $urandom_range(32000, 32768);
      default: m = $urandom_range(0, 32768);
    endcase
    return $urandom_range(0, 1) ? COS_W'(-m) : COS_W'(m);
  endfunction

  task automatic burst(int n);
    repeat (n) send(pick_cos());
  endtask

  initial begin
    static logic [COS_W-1:0] edges[] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                         16'h8001, 16'h4000, 16'hC000, 16'h0100, 16'hFF00,
                                         16'h5555, 16'hAAAA, 16'h2D41, 16'hD2BF};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (edges[i]) send(edges[i]);
    burst(150);
    settle();
    reg_write(CFG_ETA_INCIDENT, 16'd6144);
    reg_write(CFG_ETA_TRANSMITTED, 16'd4096);
    foreach (edges[i]) send(edges[i]);
    burst(150);
    settle();
    reg_write(CFG_ETA_TRANSMITTED, 16'd6144);
    burst(130);
    settle();
    reg_write(CFG_ETA_INCIDENT, 16'd1);
    reg_write(CFG_ETA_TRANSMITTED, 16'd65535);
    foreach (edges[i]) send(edges[i]);
    burst(130);
    settle();
    reg_write(CFG_ETA_INCIDENT, 16'd65535);
    reg_write(CFG_ETA_TRANSMITTED, 16'd1);
    burst(130);
    settle();
    reg_write(CFG_ETA_INCIDENT, 16'd0);
    reg_write(CFG_ETA_TRANSMITTED, 16'd5000);
    burst(60);
    settle();
    reg_write(CFG_ETA_INCIDENT, 16'd4500);
    reg_write(CFG_ETA_TRANSMITTED, 16'd0);
    burst(60);
    settle();
    reg_write(CFG_SPARE_A, 16'd123);
    reg_write(CFG_SPARE_B, 16'hFFFF);
    burst(60);
    settle();
    for (int k = 0; k < 4; k++) begin
      reg_write(CFG_ETA_INCIDENT, ETA_W'($urandom_range(1, 65535)));
      reg_write(CFG_ETA_TRANSMITTED, ETA_W'($urandom_range(1, 65535)));
      burst(90);
      settle();
    end
    $display("covered %0d cosines, %0d results checked (%0d total internal), %0d register writes",
             board.taken, board.checked, board.tir_seen, cfg_writes);
    if (board.errors == 0 && board.want_refl.size() == 0) begin
      $display("PASS fresnel_dielectric_reflectance_unit");
    end else begin
      $display("FAIL fresnel_dielectric_reflectance_unit");
    end
    $finish;
  end
endmodule
